FILE: rtl/complex_integer_accumulator_macros.svh
// Assertion helpers for the complex integer accumulator.
// CIA_ASSERT checks a condition at every clock edge out of reset.
// CIA_ASSERT_NEXT checks that a condition holds in the cycle after a trigger.
`ifndef COMPLEX_INTEGER_ACCUMULATOR_MACROS_SVH
`define COMPLEX_INTEGER_ACCUMULATOR_MACROS_SVH
`ifndef SYNTHESIS
`define CIA_ASSERT(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define CIA_ASSERT_NEXT(name, trig, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);
`else
`define CIA_ASSERT(name, cond, msg)
`define CIA_ASSERT_NEXT(name, trig, cond, msg)
`endif
`endif

FILE: rtl/cia_pkg.sv
package cia_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FIELD_W        = 32;
	localparam int OPCODE_W       = 3;
	localparam int CHUNK_W        = 16;  // multiplier operand slice per cycle
	localparam int PIDX_W         = 3;
	localparam int MUL_PRODUCTS   = 4;
	localparam int DIV_PRODUCTS   = 6;

	localparam logic [OPCODE_W-1:0] OP_LOAD = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_ADD  = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_SUB  = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_MUL  = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_DIV  = 3'd4;

	// controller -> datapath
	typedef struct packed {
		logic                load;      // latch operands, clear product sums
		logic                mac;       // multiply-accumulate one slice
		logic                first;     // first slice of a product
		logic [PIDX_W-1:0]   pidx;      // which product
		logic                div_load;  // set up the divider
		logic                div_step;  // one quotient bit
		logic                finish;    // update accumulator and result
		logic [OPCODE_W-1:0] op;
	} cmd_t;

endpackage

FILE: rtl/cia_ctrl.sv
`include "complex_integer_accumulator_macros.svh"

module cia_ctrl #(
	parameter int DATA_WIDTH = cia_pkg::DATA_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [cia_pkg::OPCODE_W-1:0]  opcode,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic                          den_zero,
	output cia_pkg::cmd_t                 cmd
);

	localparam int NCH = (DATA_WIDTH + cia_pkg::CHUNK_W - 1) / cia_pkg::CHUNK_W;
	localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int DCW = $clog2(DATA_WIDTH);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MAC   = 3'd1;
	localparam logic [2:0] S_DPREP = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]                    state_q;
	logic [cia_pkg::OPCODE_W-1:0]  op_q;
	logic [cia_pkg::PIDX_W-1:0]    pidx_q;
	logic [cia_pkg::PIDX_W-1:0]    pidx_last;
	logic [CW-1:0]                 chk_q;
	logic [DCW-1:0]                cnt_q;
	logic                          m_tvalid_q;
	logic                          out_free;
	logic                          accept;

	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign pidx_last = (op_q == cia_pkg::OP_DIV) ?
		cia_pkg::PIDX_W'(cia_pkg::DIV_PRODUCTS - 1) :
		cia_pkg::PIDX_W'(cia_pkg::MUL_PRODUCTS - 1);

	always_comb begin
		cmd          = '0;
		cmd.op       = op_q;
		cmd.pidx     = pidx_q;
		cmd.first    = (chk_q == '0);
		cmd.load     = accept;
		cmd.mac      = (state_q == S_MAC);
		cmd.div_load = (state_q == S_DPREP);
		cmd.div_step = (state_q == S_DIV);
		cmd.finish   = (state_q == S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			op_q       <= cia_pkg::OP_LOAD;
			pidx_q     <= '0;
			chk_q      <= '0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q   <= opcode;
						pidx_q <= '0;
						chk_q  <= '0;
						if (opcode inside {cia_pkg::OP_MUL, cia_pkg::OP_DIV}) begin
							state_q <= S_MAC;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_MAC: begin
					if (chk_q == CW'(NCH - 1)) begin
						chk_q  <= '0;
						pidx_q <= pidx_q + 1'b1;
						if (pidx_q == pidx_last) begin
							state_q <= (op_q == cia_pkg::OP_DIV) ? S_DPREP : S_DONE;
						end
					end else begin
						chk_q <= chk_q + 1'b1;
					end
				end
				S_DPREP: begin
					cnt_q   <= '0;
					state_q <= den_zero ? S_DONE : S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DCW'(DATA_WIDTH - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`CIA_ASSERT_NEXT(a_accept_dispatch, accept, state_q == S_MAC || state_q == S_DONE, "bad dispatch")
	`CIA_ASSERT(a_no_overwrite, !(cmd.finish && m_tvalid_q && !m_tready), "result overwritten")
	`CIA_ASSERT_NEXT(a_result_shown, cmd.finish, m_tvalid_q, "result not presented")
	`CIA_ASSERT(a_div_only_divide, state_q != S_DIV || op_q == cia_pkg::OP_DIV, "divider misuse")
	`CIA_ASSERT(a_pidx_range, pidx_q <= cia_pkg::PIDX_W'(cia_pkg::DIV_PRODUCTS), "product index")

endmodule

FILE: rtl/cia_datapath.sv
module cia_datapath #(
	parameter int DATA_WIDTH = cia_pkg::DATA_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cia_pkg::cmd_t                       cmd,
	input  logic signed [cia_pkg::FIELD_W-1:0]  operand_real,
	input  logic signed [cia_pkg::FIELD_W-1:0]  operand_imag,
	output logic                                den_zero,
	output logic signed [cia_pkg::FIELD_W-1:0]  result_real,
	output logic signed [cia_pkg::FIELD_W-1:0]  result_imag,
	output logic                                divide_by_zero
);

	localparam int W   = DATA_WIDTH;
	localparam int CHW = cia_pkg::CHUNK_W;
	localparam int NCH = (W + CHW - 1) / CHW;
	localparam int YW  = NCH * CHW;

	function automatic logic [W-1:0] mag(input logic [W-1:0] v);
		return v[W-1] ? (W'(0) - v) : v;
	endfunction

	// architectural state
	logic [W-1:0] acc_re_q, acc_im_q;
	// working registers
	logic [W-1:0] opr_re_q, opr_im_q;
	logic [W-1:0] t_re_q, t_im_q, den_q;
	logic [W-1:0] x_sh_q;
	logic [YW-1:0] y_sh_q;
	logic [W-1:0] nre_q, nim_q, rre_q, rim_q, dvs_q;
	logic         neg_re_q, neg_im_q, dz_q;
	logic [cia_pkg::FIELD_W-1:0] res_re_q, res_im_q;
	logic                        res_dz_q;

	logic [W-1:0]     src_x, src_y, x_cur, part, dest, dest_nx;
	logic [YW-1:0]    y_cur;
	logic             sub;
	logic [W-1:0]     sh_re, sh_im;
	logic             ge_re, ge_im;
	logic [W-1:0]     q_re, q_im, nx_re, nx_im;

	assign den_zero = (den_q == '0);

	// product schedule: ac, bd, bc, ad, cc, dd
	always_comb begin
		case (cmd.pidx)
			3'd0:    begin src_x = acc_re_q; src_y = opr_re_q; end
			3'd1:    begin src_x = acc_im_q; src_y = opr_im_q; end
			3'd2:    begin src_x = acc_im_q; src_y = opr_re_q; end
			3'd3:    begin src_x = acc_re_q; src_y = opr_im_q; end
			3'd4:    begin src_x = opr_re_q; src_y = opr_re_q; end
			default: begin src_x = opr_im_q; src_y = opr_im_q; end
		endcase
		x_cur     = cmd.first ? src_x : x_sh_q;
		y_cur     = cmd.first ? YW'(src_y) : y_sh_q;
		// only the low W bits of each partial product matter
		part      = x_cur * W'(y_cur[CHW-1:0]);
		sub       = (cmd.op == cia_pkg::OP_MUL && cmd.pidx == 3'd1) ||
		            (cmd.op == cia_pkg::OP_DIV && cmd.pidx == 3'd3);
		case (cmd.pidx[2:1])
			2'b00:   dest = t_re_q;
			2'b01:   dest = t_im_q;
			default: dest = den_q;
		endcase
		dest_nx = sub ? (dest - part) : (dest + part);
	end

	// one restoring step on both numerators
	always_comb begin
		sh_re = {rre_q[W-2:0], nre_q[W-1]};
		sh_im = {rim_q[W-2:0], nim_q[W-1]};
		ge_re = (sh_re >= dvs_q);
		ge_im = (sh_im >= dvs_q);
		q_re  = neg_re_q ? (W'(0) - nre_q) : nre_q;
		q_im  = neg_im_q ? (W'(0) - nim_q) : nim_q;
	end

	always_comb begin
		case (cmd.op)
			cia_pkg::OP_LOAD: begin nx_re = opr_re_q; nx_im = opr_im_q; end
			cia_pkg::OP_ADD:  begin nx_re = acc_re_q + opr_re_q; nx_im = acc_im_q + opr_im_q; end
			cia_pkg::OP_SUB:  begin nx_re = acc_re_q - opr_re_q; nx_im = acc_im_q - opr_im_q; end
			cia_pkg::OP_MUL:  begin nx_re = t_re_q; nx_im = t_im_q; end
			cia_pkg::OP_DIV: begin
				nx_re = dz_q ? acc_re_q : q_re;
				nx_im = dz_q ? acc_im_q : q_im;
			end
			default:          begin nx_re = acc_re_q; nx_im = acc_im_q; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (cmd.finish) begin
			acc_re_q <= nx_re;
			acc_im_q <= nx_im;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			opr_re_q <= W'(operand_real);
			opr_im_q <= W'(operand_imag);
			t_re_q   <= '0;
			t_im_q   <= '0;
			den_q    <= '0;
		end
		if (cmd.mac) begin
			x_sh_q <= x_cur << CHW;
			y_sh_q <= y_cur >> CHW;
			case (cmd.pidx[2:1])
				2'b00:   t_re_q <= dest_nx;
				2'b01:   t_im_q <= dest_nx;
				default: den_q  <= dest_nx;
			endcase
		end
		if (cmd.div_load) begin
			nre_q    <= mag(t_re_q);
			nim_q    <= mag(t_im_q);
			dvs_q    <= mag(den_q);
			rre_q    <= '0;
			rim_q    <= '0;
			neg_re_q <= t_re_q[W-1] ^ den_q[W-1];
			neg_im_q <= t_im_q[W-1] ^ den_q[W-1];
			dz_q     <= den_zero;
		end
		if (cmd.div_step) begin
			rre_q <= ge_re ? (sh_re - dvs_q) : sh_re;
			rim_q <= ge_im ? (sh_im - dvs_q) : sh_im;
			nre_q <= {nre_q[W-2:0], ge_re};
			nim_q <= {nim_q[W-2:0], ge_im};
		end
		if (cmd.finish) begin
			res_re_q <= cia_pkg::FIELD_W'($signed(nx_re));
			res_im_q <= cia_pkg::FIELD_W'($signed(nx_im));
			res_dz_q <= (cmd.op == cia_pkg::OP_DIV) && dz_q;
		end
	end

	assign result_real    = res_re_q;
	assign result_imag    = res_im_q;
	assign divide_by_zero = res_dz_q;

endmodule

FILE: rtl/complex_integer_accumulator.sv
// Complex integer accumulator: holds acc = re + j*im (DATA_WIDTH bits each, two's
// complement, reset to zero) and applies one opcode per input item (load, add,
// subtract, multiply, divide; unused codes leave acc alone), returning the new
// acc on every item. All arithmetic wraps at DATA_WIDTH bits like C int. Divide
// computes acc*conj(op)/|op|^2 with both parts truncated toward zero; a wrapped
// |op|^2 of zero leaves acc unchanged and sets divide_by_zero. Operands are
// sign-extended or truncated to DATA_WIDTH; results carry acc sign-extended or
// truncated to 32 bits. One item is in flight at a time. Multiply and divide
// use a single shared W x 16 multiplier (W = DATA_WIDTH) taking one 16-bit
// slice of the operand per cycle; divide then runs a radix-2 restoring divider
// that produces one quotient bit per cycle for both parts in parallel, and is
// skipped when the wrapped |op|^2 is zero. A new item is taken while the
// previous result still waits in the output register.
module complex_integer_accumulator #(
	parameter int DATA_WIDTH = cia_pkg::DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] operand_real, [63:32] operand_imag
	input  logic [2:0]  s_tuser,   // [2:0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] result_real, [63:32] result_imag
	output logic [0:0]  m_tuser    // [0] divide_by_zero
);

	cia_pkg::cmd_t cmd;
	logic          den_zero;
	logic signed [cia_pkg::FIELD_W-1:0] result_real, result_imag;
	logic          divide_by_zero;

	// sequencing: operand latch, product schedule, divider, output handshake
	cia_ctrl #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.opcode   (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.den_zero (den_zero),
		.cmd      (cmd)
	);

	// accumulator, sliced multiplier, divider and result register
	cia_datapath #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.operand_real   (s_tdata[31:0]),
		.operand_imag   (s_tdata[63:32]),
		.den_zero       (den_zero),
		.result_real    (result_real),
		.result_imag    (result_imag),
		.divide_by_zero (divide_by_zero)
	);

	assign m_tdata = {result_imag, result_real};
	assign m_tuser = divide_by_zero;

endmodule
